// File: src/tgm_pkg.sv
// tgm_pkg: shared widths, codes, command/status structs and the cordic angle table
// for the tremolo gain modulator; no dependencies
`timescale 1ns / 1ps

package tgm_pkg;

  // frame format
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FRAC_BITS   = 16;
  localparam int GAIN_BITS   = 17;

  localparam int IN_DATA_BITS  = FRAC_BITS + CHANNELS * SAMPLE_BITS;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = CHANNELS * SAMPLE_BITS + GAIN_BITS;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FPB    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SRATE  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd7;

  // divider: 48-bit dividend, 32-bit divisor, one quotient bit per cycle
  localparam int DIV_NW    = 48;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = 6;

  // cordic: 36-bit signed lanes, angles in units of 2^-32 turn
  localparam int COR_W     = 36;
  localparam int COR_STEPS = 24;
  localparam int COR_CNT_W = 5;
  localparam logic signed [COR_W-1:0] COR_X0   = 36'sd652032874;
  localparam logic signed [COR_W-1:0] COR_ONE  = 36'sd1073741824;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 17'd65536;
  localparam logic [GAIN_BITS-1:0] SLEW_STEP = 17'd66;
  localparam logic [23:0]          PERIOD_MAX = 24'h800000;

  function automatic logic signed [COR_W-1:0] turn_atan(input logic [COR_CNT_W-1:0] i);
    logic signed [COR_W-1:0] v;
    case (i)
      5'd0:  v = 36'sd536870912;
      5'd1:  v = 36'sd316933406;
      5'd2:  v = 36'sd167458907;
      5'd3:  v = 36'sd85004756;
      5'd4:  v = 36'sd42667331;
      5'd5:  v = 36'sd21354465;
      5'd6:  v = 36'sd10679838;
      5'd7:  v = 36'sd5340245;
      5'd8:  v = 36'sd2670163;
      5'd9:  v = 36'sd1335087;
      5'd10: v = 36'sd667544;
      5'd11: v = 36'sd333772;
      5'd12: v = 36'sd166886;
      5'd13: v = 36'sd83443;
      5'd14: v = 36'sd41722;
      5'd15: v = 36'sd20861;
      5'd16: v = 36'sd10430;
      5'd17: v = 36'sd5215;
      5'd18: v = 36'sd2608;
      5'd19: v = 36'sd1304;
      5'd20: v = 36'sd652;
      5'd21: v = 36'sd326;
      5'd22: v = 36'sd163;
      5'd23: v = 36'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_PER_GO, OP_PER_FIX,
    OP_MOD_GO, OP_MOD_FIX,
    OP_FRAC_GO, OP_FRAC_FIX,
    OP_BEND_GO, OP_BEND_FIX,
    OP_SIN_GO, OP_SIN_FIX,
    OP_NUM_GO, OP_NUM_FIX,
    OP_DEN_GO, OP_DEN_FIX,
    OP_RAT_GO, OP_RAT_FIX,
    OP_TGT, OP_SLEW, OP_CHAN, OP_EMIT
  } dp_op_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_PER_GO, S_PER_WAIT, S_PER_FIX,
    S_MOD_GO, S_MOD_WAIT, S_MOD_FIX,
    S_FRAC_GO, S_FRAC_WAIT, S_FRAC_FIX,
    S_BEND_GO, S_BEND_WAIT, S_BEND_FIX,
    S_SIN_GO, S_SIN_WAIT, S_SIN_FIX,
    S_NUM_GO, S_NUM_WAIT, S_NUM_FIX,
    S_DEN_GO, S_DEN_WAIT, S_DEN_FIX,
    S_RAT_GO, S_RAT_WAIT, S_RAT_FIX,
    S_TGT, S_SLEW, S_CHAN, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
    logic   div_start;
    logic   cor_start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cor_busy;
    logic chan_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/tremolo_gain_modulator_core.sv
// tremolo_gain_modulator_core: top level of the tremolo gain modulator
// joins tgm_ctrl and tgm_datapath; depends on tgm_pkg
//
//  channel   ports                          payload
//  input     in_tvalid/in_tready/in_tdata   start_fraction, sample_ch0..; tuser restart
//  output    out_tvalid/out_tready/out_tdata out_ch0.., applied_gain
//  config    cfg_we/cfg_addr/cfg_wdata      register index 0..7, value
//
//  one frame steps from the idle state, which takes the item, through five divides
//  (start, busy wait, capture), three cordic runs, target, slew, one step per channel
//  and emit
//  out_tvalid is registered and is set by the emit step
//  the finished frame sits in the output register, so the next frame is taken
//  while it waits; a stalled output holds the sequencer only at its last step
//  rst_n is synchronous and active low; it restores register defaults and
//  clears the frame counter, gain and mode history
`timescale 1ns / 1ps

module tremolo_gain_modulator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_fraction [15:0], sample_ch0, sample_ch1 (24b each)
  input  logic [tgm_pkg::IN_DATA_W-1:0]   in_tdata,
  // restart
  input  logic                            in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_ch0, out_ch1 (24b each), applied_gain (17b), zero pad
  output logic [tgm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [tgm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tgm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  tgm_pkg::dp_cmd_t  cmd;
  tgm_pkg::dp_stat_t stat;

  tgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tgm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/tgm_div.sv
// tgm_div: restoring unsigned divider, one quotient bit per cycle
// depends on tgm_pkg for its widths
`timescale 1ns / 1ps

module tgm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tgm_pkg::DIV_NW-1:0] dividend,
  input  logic [tgm_pkg::DIV_DW-1:0] divisor,
  output logic                      busy,
  output logic [tgm_pkg::DIV_NW-1:0] quotient,
  output logic [tgm_pkg::DIV_DW-1:0] remainder
);

  logic [tgm_pkg::DIV_NW-1:0]    quo_r;
  logic [tgm_pkg::DIV_DW-1:0]    rem_r;
  logic [tgm_pkg::DIV_DW-1:0]    dvs_r;
  logic [tgm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic [tgm_pkg::DIV_DW:0]      trial;
  logic                          ge;

  assign trial = {rem_r, quo_r[tgm_pkg::DIV_NW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == tgm_pkg::DIV_CNT_W'(tgm_pkg::DIV_NW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? tgm_pkg::DIV_DW'(trial - {1'b0, dvs_r}) : trial[tgm_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[tgm_pkg::DIV_NW-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: src/tgm_cordic.sv
// tgm_cordic: iterative cordic, rotation or vectoring, one micro-rotation per cycle
// depends on tgm_pkg for widths and the angle table
`timescale 1ns / 1ps

module tgm_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              rot,
  input  logic signed [tgm_pkg::COR_W-1:0]  x0,
  input  logic signed [tgm_pkg::COR_W-1:0]  y0,
  input  logic signed [tgm_pkg::COR_W-1:0]  z0,
  output logic                              busy,
  output logic signed [tgm_pkg::COR_W-1:0]  x,
  output logic signed [tgm_pkg::COR_W-1:0]  y,
  output logic signed [tgm_pkg::COR_W-1:0]  z
);

  logic signed [tgm_pkg::COR_W-1:0] x_r, y_r, z_r;
  logic signed [tgm_pkg::COR_W-1:0] xs, ys, at;
  logic [tgm_pkg::COR_CNT_W-1:0]    cnt_r;
  logic                             busy_r, rot_r, pos;

  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign at  = tgm_pkg::turn_atan(cnt_r);
  // rotation follows the residual angle, vectoring drives y to zero
  assign pos = rot_r ? (z_r >= 0) : (y_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == tgm_pkg::COR_CNT_W'(tgm_pkg::COR_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      rot_r <= rot;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign busy = busy_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// File: src/tgm_datapath.sv
// tgm_datapath: configuration registers, frame state, operand selection and result
// registers; holds the shared divider and cordic; depends on tgm_pkg, tgm_div, tgm_cordic
`timescale 1ns / 1ps

module tgm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tgm_pkg::dp_cmd_t                cmd,
  output tgm_pkg::dp_stat_t               stat,
  input  logic                            cfg_we,
  input  logic [tgm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tgm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [tgm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tgm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int SB = tgm_pkg::SAMPLE_BITS;
  localparam int NW = tgm_pkg::DIV_NW;
  localparam int DW = tgm_pkg::DIV_DW;
  localparam int CW = tgm_pkg::COR_W;
  localparam logic signed [CW-1:0] COR_ONE_C = tgm_pkg::COR_ONE;

  // configuration
  logic [16:0] depth_r, smooth_r;
  logic [15:0] width_r, phase_r, rate_r;
  logic [19:0] fpb_r;
  logic [17:0] srate_r;
  logic [1:0]  mode_r;

  // frame state and intermediates
  logic signed [SB-1:0] samp_r   [tgm_pkg::CHANNELS];
  logic        [SB-1:0] outbuf_r [tgm_pkg::CHANNELS];
  logic [22:0] fc_r, fcm_r;
  logic [16:0] gain_r;
  logic        lastq_r, lastt_r;
  logic [23:0] period_r, off_r;
  logic [15:0] p_r, b_r;
  logic        bend_hi_r;
  logic signed [CW-1:0] sine_r, num_r;
  logic [DW-1:0]        den_r;
  logic signed [16:0]   ratio_r;
  logic signed [34:0]   prod_r;
  logic [tgm_pkg::CH_W-1:0] ch_r;
  logic                 out_valid_r;
  logic [tgm_pkg::OUT_DATA_W-1:0] out_data_r, out_pack;

  // unit handshakes
  logic [NW-1:0] div_dvd, div_quo;
  logic [DW-1:0] div_dvs, div_rem;
  logic          div_busy, cor_busy, cor_rot;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;

  // ---------------- period operands ----------------
  logic [15:0] rate_eff;
  logic [3:0]  msb_k, e_hi, e_lo;
  logic        pow2, tempo, quant, trip;
  logic [31:0] fpb_shl;

  assign quant    = mode_r[0];
  assign trip     = mode_r[1];
  assign tempo    = (fpb_r != 20'd0);
  assign rate_eff = (rate_r == 16'd0) ? 16'd1 : rate_r;
  assign pow2     = ((rate_eff & (rate_eff - 16'd1)) == 16'd0);

  always_comb begin
    msb_k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (rate_eff[i]) msb_k = 4'(i);
    end
  end

  always_comb begin
    if (rate_eff[15])      e_hi = 4'd3;
    else if (rate_eff[14]) e_hi = 4'd2;
    else if (rate_eff[13]) e_hi = 4'd1;
    else                   e_hi = 4'd0;
  end

  // floor(log2(4096 / r)) for rates below one
  assign e_lo    = 4'd11 - msb_k + {3'd0, pow2};
  assign fpb_shl = {12'd0, fpb_r} << e_lo;

  // ---------------- later operands ----------------
  logic [24:0] pos_sum;
  logic [23:0] pos;
  logic [15:0] w_eff;
  logic        bend_lo;
  logic [16:0] smooth_eff;
  logic signed [CW-1:0] sm, angle, num_mag;

  assign pos_sum = ({2'd0, fcm_r} >= {1'b0, off_r}) ?
                   ({2'd0, fcm_r} - {1'b0, off_r}) :
                   ({2'd0, fcm_r} + {1'b0, period_r} - {1'b0, off_r});
  assign pos     = pos_sum[23:0];

  assign w_eff   = (width_r == 16'd0) ? 16'd1 : width_r;
  assign bend_lo = (p_r < w_eff);

  assign smooth_eff = (smooth_r == 17'd0) ? 17'd1 : smooth_r;
  assign sm         = CW'($signed({1'b0, smooth_eff, 14'd0}));
  assign num_mag    = (num_r < 0) ? -num_r : num_r;

  // fold the turn into the principal range of the rotation
  always_comb begin
    if (b_r >= 16'd16384 && b_r < 16'd49152) begin
      angle = CW'(36'sh080000000) - CW'($signed({1'b0, b_r, 16'd0}));
    end else if (b_r >= 16'd49152) begin
      angle = CW'($signed({1'b0, b_r, 16'd0})) - CW'(36'sh100000000);
    end else begin
      angle = CW'($signed({1'b0, b_r, 16'd0}));
    end
  end

  // ---------------- divider operand select ----------------
  always_comb begin
    div_dvd = '0;
    div_dvs = DW'(1);
    case (cmd.op)
      tgm_pkg::OP_PER_GO: begin
        if (tempo && quant) begin
          div_dvs = trip ? DW'(3) : DW'(1);
          if (rate_eff >= 16'd4096) div_dvd = NW'(fpb_r >> e_hi);
          else                      div_dvd = NW'(fpb_shl);
        end else begin
          div_dvs = DW'(rate_eff);
          div_dvd = tempo ? NW'({fpb_r, 12'd0}) : NW'({srate_r, 12'd0});
        end
      end
      tgm_pkg::OP_MOD_GO: begin
        div_dvd = NW'(fc_r);
        div_dvs = DW'(period_r);
      end
      tgm_pkg::OP_FRAC_GO: begin
        div_dvd = NW'({pos, 16'd0});
        div_dvs = DW'(period_r);
      end
      tgm_pkg::OP_BEND_GO: begin
        if (bend_lo) begin
          div_dvd = NW'({p_r, 15'd0});
          div_dvs = DW'(w_eff);
        end else begin
          div_dvd = NW'({16'(p_r - w_eff), 15'd0});
          div_dvs = DW'(17'h10000 - {1'b0, w_eff});
        end
      end
      tgm_pkg::OP_RAT_GO: begin
        div_dvd = {num_mag[31:0], 16'd0};
        div_dvs = den_r;
      end
      default: ;
    endcase
  end

  // ---------------- cordic operand select ----------------
  always_comb begin
    cor_rot = 1'b0;
    cor_x0  = sm;
    cor_y0  = COR_ONE_C;
    cor_z0  = '0;
    case (cmd.op)
      tgm_pkg::OP_SIN_GO: begin
        cor_rot = 1'b1;
        cor_x0  = tgm_pkg::COR_X0;
        cor_y0  = '0;
        cor_z0  = angle;
      end
      tgm_pkg::OP_NUM_GO: cor_y0 = sine_r;
      default: ;
    endcase
  end

  tgm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  tgm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cor_start),
    .rot   (cor_rot),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .busy  (cor_busy),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  // ---------------- result arithmetic ----------------
  logic [35:0] resync_prod;
  logic [39:0] off_prod;
  logic signed [CW-1:0] den2;
  logic [16:0] rat_mag;
  logic signed [17:0] rat_s;
  logic signed [36:0] tsum;
  logic signed [20:0] tq;
  logic signed [18:0] tclamp, g_s, g_up, g_dn;
  logic [16:0] g_nxt;
  logic signed [SB+17:0] ch_prod, ch_rnd;

  assign resync_prod = in_tdata[15:0] * fpb_r;
  assign off_prod    = phase_r * period_r;
  assign den2        = cor_z <<< 1;
  assign rat_mag     = (div_quo > NW'(32768)) ? 17'd32768 : div_quo[16:0];
  assign rat_s       = (num_r < 0) ? -$signed({1'b0, rat_mag}) : $signed({1'b0, rat_mag});

  assign tsum = 37'sh100000000 - $signed({5'd0, depth_r, 15'd0})
                + 37'(prod_r) + 37'sd32768;
  assign tq   = 21'(tsum >>> 16);

  always_comb begin
    if (tq < 0)                                       tclamp = '0;
    else if (tq > $signed({4'd0, tgm_pkg::GAIN_ONE})) tclamp = $signed({2'd0, tgm_pkg::GAIN_ONE});
    else                                              tclamp = 19'(tq);
  end

  assign g_s  = $signed({2'd0, gain_r});
  assign g_up = g_s + $signed({2'd0, tgm_pkg::SLEW_STEP});
  assign g_dn = g_s - $signed({2'd0, tgm_pkg::SLEW_STEP});

  always_comb begin
    if (tclamp > g_up)      g_nxt = g_up[16:0];
    else if (tclamp < g_dn) g_nxt = g_dn[16:0];
    else                    g_nxt = tclamp[16:0];
  end

  assign ch_prod = samp_r[ch_r] * $signed({1'b0, gain_r});
  assign ch_rnd  = (ch_prod + (SB + 18)'(32768)) >>> 16;

  always_comb begin
    out_pack = '0;
    for (int c = 0; c < tgm_pkg::CHANNELS; c++) begin
      out_pack[c*SB +: SB] = outbuf_r[c];
    end
    out_pack[tgm_pkg::CHANNELS*SB +: tgm_pkg::GAIN_BITS] = gain_r;
  end

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= 17'd65536;
      width_r  <= 16'd32768;
      smooth_r <= 17'd32768;
      phase_r  <= 16'd0;
      rate_r   <= 16'd4096;
      fpb_r    <= 20'd0;
      srate_r  <= 18'd48000;
      mode_r   <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        tgm_pkg::REG_DEPTH:  depth_r  <= cfg_wdata[16:0];
        tgm_pkg::REG_WIDTH:  width_r  <= cfg_wdata[15:0];
        tgm_pkg::REG_SMOOTH: smooth_r <= cfg_wdata[16:0];
        tgm_pkg::REG_PHASE:  phase_r  <= cfg_wdata[15:0];
        tgm_pkg::REG_RATE:   rate_r   <= cfg_wdata[15:0];
        tgm_pkg::REG_FPB:    fpb_r    <= cfg_wdata[19:0];
        tgm_pkg::REG_SRATE:  srate_r  <= cfg_wdata[17:0];
        tgm_pkg::REG_MODE:   mode_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // ---------------- frame state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      gain_r      <= '0;
      lastq_r     <= 1'b0;
      lastt_r     <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (cmd.accept) begin
        ch_r <= '0;
        // resync on restart, quantize rising or triplet falling
        if (in_tuser || (quant && !lastq_r) || (!trip && lastt_r)) begin
          fc_r   <= 23'(resync_prod >> 16);
          gain_r <= '0;
        end
      end
      if (cmd.op == tgm_pkg::OP_SLEW) gain_r <= g_nxt;
      if (cmd.op == tgm_pkg::OP_CHAN) ch_r <= ch_r + 1'b1;
      if (cmd.op == tgm_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
        fc_r        <= fcm_r + 23'd1;
        lastq_r     <= quant;
        lastt_r     <= trip;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int c = 0; c < tgm_pkg::CHANNELS; c++) begin
        samp_r[c] <= $signed(in_tdata[tgm_pkg::FRAC_BITS + c*SB +: SB]);
      end
    end
    case (cmd.op)
      tgm_pkg::OP_PER_FIX: begin
        if (div_quo == '0)                   period_r <= 24'd1;
        else if (div_quo > NW'(tgm_pkg::PERIOD_MAX)) period_r <= tgm_pkg::PERIOD_MAX;
        else                                 period_r <= div_quo[23:0];
      end
      tgm_pkg::OP_MOD_FIX: begin
        fcm_r <= div_rem[22:0];
        off_r <= off_prod[39:16];
      end
      tgm_pkg::OP_FRAC_FIX: p_r <= div_quo[15:0];
      tgm_pkg::OP_BEND_GO:  bend_hi_r <= !bend_lo;
      tgm_pkg::OP_BEND_FIX: b_r <= {bend_hi_r, div_quo[14:0]};
      tgm_pkg::OP_SIN_FIX:  sine_r <= cor_y;
      tgm_pkg::OP_NUM_FIX:  num_r <= cor_z;
      tgm_pkg::OP_DEN_FIX:  den_r <= (den2 <= 0) ? DW'(1) : den2[DW-1:0];
      tgm_pkg::OP_RAT_FIX:  ratio_r <= rat_s[16:0];
      tgm_pkg::OP_TGT:      prod_r <= ratio_r * $signed({1'b0, depth_r});
      tgm_pkg::OP_CHAN:     outbuf_r[ch_r] <= ch_rnd[SB-1:0];
      tgm_pkg::OP_EMIT:     out_data_r <= out_pack;
      default: ;
    endcase
  end

  assign stat.div_busy  = div_busy;
  assign stat.cor_busy  = cor_busy;
  assign stat.chan_last = (ch_r == tgm_pkg::CH_W'(tgm_pkg::CHANNELS - 1));
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= tgm_pkg::GAIN_ONE) else $error("gain above unity");
  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tgm_pkg::OP_MOD_GO) |-> (period_r != 24'd0 && period_r <= tgm_pkg::PERIOD_MAX))
    else $error("period out of range");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tgm_pkg::OP_EMIT) |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
`endif

endmodule

// File: src/tgm_ctrl.sv
// tgm_ctrl: sequencer that steps one frame through the datapath operations
// depends on tgm_pkg for states, operations and the command/status structs
`timescale 1ns / 1ps

module tgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tgm_pkg::dp_stat_t stat,
  output tgm_pkg::dp_cmd_t  cmd
);

  tgm_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tgm_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgm_pkg::S_IDLE:      if (in_tvalid) state_nxt = tgm_pkg::S_PER_GO;
      tgm_pkg::S_PER_GO:    state_nxt = tgm_pkg::S_PER_WAIT;
      tgm_pkg::S_PER_WAIT:  if (!stat.div_busy) state_nxt = tgm_pkg::S_PER_FIX;
      tgm_pkg::S_PER_FIX:   state_nxt = tgm_pkg::S_MOD_GO;
      tgm_pkg::S_MOD_GO:    state_nxt = tgm_pkg::S_MOD_WAIT;
      tgm_pkg::S_MOD_WAIT:  if (!stat.div_busy) state_nxt = tgm_pkg::S_MOD_FIX;
      tgm_pkg::S_MOD_FIX:   state_nxt = tgm_pkg::S_FRAC_GO;
      tgm_pkg::S_FRAC_GO:   state_nxt = tgm_pkg::S_FRAC_WAIT;
      tgm_pkg::S_FRAC_WAIT: if (!stat.div_busy) state_nxt = tgm_pkg::S_FRAC_FIX;
      tgm_pkg::S_FRAC_FIX:  state_nxt = tgm_pkg::S_BEND_GO;
      tgm_pkg::S_BEND_GO:   state_nxt = tgm_pkg::S_BEND_WAIT;
      tgm_pkg::S_BEND_WAIT: if (!stat.div_busy) state_nxt = tgm_pkg::S_BEND_FIX;
      tgm_pkg::S_BEND_FIX:  state_nxt = tgm_pkg::S_SIN_GO;
      tgm_pkg::S_SIN_GO:    state_nxt = tgm_pkg::S_SIN_WAIT;
      tgm_pkg::S_SIN_WAIT:  if (!stat.cor_busy) state_nxt = tgm_pkg::S_SIN_FIX;
      tgm_pkg::S_SIN_FIX:   state_nxt = tgm_pkg::S_NUM_GO;
      tgm_pkg::S_NUM_GO:    state_nxt = tgm_pkg::S_NUM_WAIT;
      tgm_pkg::S_NUM_WAIT:  if (!stat.cor_busy) state_nxt = tgm_pkg::S_NUM_FIX;
      tgm_pkg::S_NUM_FIX:   state_nxt = tgm_pkg::S_DEN_GO;
      tgm_pkg::S_DEN_GO:    state_nxt = tgm_pkg::S_DEN_WAIT;
      tgm_pkg::S_DEN_WAIT:  if (!stat.cor_busy) state_nxt = tgm_pkg::S_DEN_FIX;
      tgm_pkg::S_DEN_FIX:   state_nxt = tgm_pkg::S_RAT_GO;
      tgm_pkg::S_RAT_GO:    state_nxt = tgm_pkg::S_RAT_WAIT;
      tgm_pkg::S_RAT_WAIT:  if (!stat.div_busy) state_nxt = tgm_pkg::S_RAT_FIX;
      tgm_pkg::S_RAT_FIX:   state_nxt = tgm_pkg::S_TGT;
      tgm_pkg::S_TGT:       state_nxt = tgm_pkg::S_SLEW;
      tgm_pkg::S_SLEW:      state_nxt = tgm_pkg::S_CHAN;
      tgm_pkg::S_CHAN:      if (stat.chan_last) state_nxt = tgm_pkg::S_EMIT;
      tgm_pkg::S_EMIT:      if (stat.out_free) state_nxt = tgm_pkg::S_IDLE;
      default:              state_nxt = tgm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = tgm_pkg::OP_NONE;
    in_tready     = 1'b0;
    case (state_r)
      tgm_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      tgm_pkg::S_PER_GO:   begin cmd.op = tgm_pkg::OP_PER_GO;  cmd.div_start = 1'b1; end
      tgm_pkg::S_PER_FIX:  cmd.op = tgm_pkg::OP_PER_FIX;
      tgm_pkg::S_MOD_GO:   begin cmd.op = tgm_pkg::OP_MOD_GO;  cmd.div_start = 1'b1; end
      tgm_pkg::S_MOD_FIX:  cmd.op = tgm_pkg::OP_MOD_FIX;
      tgm_pkg::S_FRAC_GO:  begin cmd.op = tgm_pkg::OP_FRAC_GO; cmd.div_start = 1'b1; end
      tgm_pkg::S_FRAC_FIX: cmd.op = tgm_pkg::OP_FRAC_FIX;
      tgm_pkg::S_BEND_GO:  begin cmd.op = tgm_pkg::OP_BEND_GO; cmd.div_start = 1'b1; end
      tgm_pkg::S_BEND_FIX: cmd.op = tgm_pkg::OP_BEND_FIX;
      tgm_pkg::S_SIN_GO:   begin cmd.op = tgm_pkg::OP_SIN_GO;  cmd.cor_start = 1'b1; end
      tgm_pkg::S_SIN_FIX:  cmd.op = tgm_pkg::OP_SIN_FIX;
      tgm_pkg::S_NUM_GO:   begin cmd.op = tgm_pkg::OP_NUM_GO;  cmd.cor_start = 1'b1; end
      tgm_pkg::S_NUM_FIX:  cmd.op = tgm_pkg::OP_NUM_FIX;
      tgm_pkg::S_DEN_GO:   begin cmd.op = tgm_pkg::OP_DEN_GO;  cmd.cor_start = 1'b1; end
      tgm_pkg::S_DEN_FIX:  cmd.op = tgm_pkg::OP_DEN_FIX;
      tgm_pkg::S_RAT_GO:   begin cmd.op = tgm_pkg::OP_RAT_GO;  cmd.div_start = 1'b1; end
      tgm_pkg::S_RAT_FIX:  cmd.op = tgm_pkg::OP_RAT_FIX;
      tgm_pkg::S_TGT:      cmd.op = tgm_pkg::OP_TGT;
      tgm_pkg::S_SLEW:     cmd.op = tgm_pkg::OP_SLEW;
      tgm_pkg::S_CHAN:     cmd.op = tgm_pkg::OP_CHAN;
      tgm_pkg::S_EMIT:     if (stat.out_free) cmd.op = tgm_pkg::OP_EMIT;
      default: ;
    endcase
  end

endmodule
